[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define VR_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define VR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/vr_pkg.sv]
// Constants and fixed-point helpers for the vector refraction unit.
package vr_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    localparam int ETA_WIDTH  = 16;
    localparam int ETA_FRAC   = 12;
    localparam int IWIDTH     = 32;

    localparam logic signed [127:0] I32_MAX = 128'sh7fff_ffff;
    localparam logic signed [127:0] I32_MIN = -128'sh8000_0000;

    // round to nearest, ties toward plus infinity
    function automatic logic signed [127:0] rnd_shift(input logic signed [127:0] v,
                                                      input int unsigned s);
        return (v + (128'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic ovf32(input logic signed [127:0] v);
        return (v > I32_MAX) || (v < I32_MIN);
    endfunction

    function automatic logic signed [IWIDTH-1:0] sat32(input logic signed [127:0] v);
        logic signed [127:0] r;
        r = v;
        if (v > I32_MAX)
        begin
            r = I32_MAX;
        end
        else if (v < I32_MIN)
        begin
            r = I32_MIN;
        end
        return r[IWIDTH-1:0];
    endfunction

endpackage

[rtl/vr_if.sv]
// Channel interfaces: incoming hit words and refracted result words.
interface vr_hit_if #(
    parameter int COMP_WIDTH = vr_pkg::COMP_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] dir_x;
    logic signed [COMP_WIDTH-1:0] dir_y;
    logic signed [COMP_WIDTH-1:0] dir_z;
    logic signed [COMP_WIDTH-1:0] norm_x;
    logic signed [COMP_WIDTH-1:0] norm_y;
    logic signed [COMP_WIDTH-1:0] norm_z;
    logic [vr_pkg::ETA_WIDTH-1:0] eta_ratio;

    modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
                    input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
                  output ready);
endinterface

interface vr_res_if #(
    parameter int COMP_WIDTH = vr_pkg::COMP_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] ref_x;
    logic signed [COMP_WIDTH-1:0] ref_y;
    logic signed [COMP_WIDTH-1:0] ref_z;
    logic                         clipped;

    modport source (output valid, ref_x, ref_y, ref_z, clipped, input ready);
    modport sink (input valid, ref_x, ref_y, ref_z, clipped, output ready);
endinterface

[rtl/vector_refract_unit.sv]
// Top level: pipelined Snell refraction of a direction vector.
//
// Channels: hit (sink) carries one incident direction, unit normal and
// eta ratio per word; res (source) carries the refracted direction and a
// clipped flag. Both use valid/ready; a word moves when both are high.
// Throughput: one word per cycle, sustained while res.ready stays high.
// The depth is set by the square-root pipeline, which resolves one root
// bit per stage.
// Every stage holds a valid bit; empty stages are filled even while the
// output is stalled, so hit.ready drops only once the whole pipeline is
// full behind a stalled res. A stalled result holds its value.
// Reset clears all valid bits; no word is in flight afterwards and the
// datapath registers keep whatever they held.
module vector_refract_unit #(
    parameter int COMP_WIDTH = vr_pkg::COMP_WIDTH,
    parameter int FRAC_BITS  = vr_pkg::FRAC_BITS
) (
    input  logic clk,
    input  logic rst_n,
    vr_hit_if.sink   hit,
    vr_res_if.source res
);
    localparam int W   = COMP_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int IW  = vr_pkg::IWIDTH;
    localparam int EW  = vr_pkg::ETA_WIDTH;
    localparam int EF  = vr_pkg::ETA_FRAC;
    localparam int XW  = IW + F;
    localparam int RW  = (XW + 1) / 2;
    localparam int SW  = 2 * RW + 1;
    localparam int SQ0 = 8;
    localparam int RTS = SQ0 + RW;
    localparam int PRS = RTS + 1;
    localparam int NS  = RTS + 3;

    localparam logic signed [127:0] ONE  = 128'sd1 <<< F;
    localparam logic signed [127:0] OMAX = (128'sd1 <<< (W - 1)) - 128'sd1;
    localparam logic signed [127:0] OMIN = -(128'sd1 <<< (W - 1));

    logic [NS-1:0] valid_reg;
    logic [NS:0]   rdy;

    always_comb
    begin
        rdy[NS] = res.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign hit.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= hit.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 0: d.n products
    logic signed [W-1:0]   d_in [3];
    logic signed [W-1:0]   n_in [3];
    logic signed [2*W-1:0] p0_reg [3];
    logic signed [W-1:0]   d0_reg [3];
    logic signed [W-1:0]   n0_reg [3];
    logic [EW-1:0]         eta0_reg;

    assign d_in[0] = hit.dir_x;
    assign d_in[1] = hit.dir_y;
    assign d_in[2] = hit.dir_z;
    assign n_in[0] = hit.norm_x;
    assign n_in[1] = hit.norm_y;
    assign n_in[2] = hit.norm_z;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i] <= d_in[i] * n_in[i];
                d0_reg[i] <= d_in[i];
                n0_reg[i] <= n_in[i];
            end
            eta0_reg <= hit.eta_ratio;
        end
    end

    // stage 1: cos = min(-d.n, 1)
    logic signed [127:0]  dot_next;
    logic signed [IW-1:0] dsat;
    logic signed [IW-1:0] cos1_next;
    logic signed [IW-1:0] cos1_reg;
    logic                 clip1_reg;
    logic signed [W-1:0]  d1_reg [3];
    logic signed [W-1:0]  n1_reg [3];
    logic [EW-1:0]        eta1_reg;

    always_comb
    begin
        dot_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dot_next = dot_next + vr_pkg::rnd_shift(-128'(p0_reg[i]), F);
        end
        dsat = vr_pkg::sat32(dot_next);
        cos1_next = (128'(dsat) < ONE) ? dsat : ONE[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            cos1_reg  <= cos1_next;
            clip1_reg <= vr_pkg::ovf32(dot_next);
            d1_reg    <= d0_reg;
            n1_reg    <= n0_reg;
            eta1_reg  <= eta0_reg;
        end
    end

    // stage 2: cos * n
    logic signed [IW+W-1:0] cn2_reg [3];
    logic signed [W-1:0]    d2_reg [3];
    logic signed [W-1:0]    n2_reg [3];
    logic [EW-1:0]          eta2_reg;
    logic                   clip2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                cn2_reg[i] <= cos1_reg * n1_reg[i];
            end
            d2_reg    <= d1_reg;
            n2_reg    <= n1_reg;
            eta2_reg  <= eta1_reg;
            clip2_reg <= clip1_reg;
        end
    end

    // stage 3: t = d + cos * n
    logic signed [127:0]  t_next [3];
    logic                 clip3_next;
    logic signed [IW-1:0] t3_reg [3];
    logic signed [W-1:0]  n3_reg [3];
    logic [EW-1:0]        eta3_reg;
    logic                 clip3_reg;

    always_comb
    begin
        clip3_next = clip2_reg;
        for (int i = 0; i < 3; i++)
        begin
            t_next[i] = 128'(d2_reg[i]) + vr_pkg::rnd_shift(128'(cn2_reg[i]), F);
            clip3_next = clip3_next | vr_pkg::ovf32(t_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                t3_reg[i] <= vr_pkg::sat32(t_next[i]);
            end
            n3_reg    <= n2_reg;
            eta3_reg  <= eta2_reg;
            clip3_reg <= clip3_next;
        end
    end

    // stage 4: eta * t
    logic signed [EW+IW:0] et4_reg [3];
    logic signed [W-1:0]   n4_reg [3];
    logic                  clip4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                et4_reg[i] <= $signed({1'b0, eta3_reg}) * t3_reg[i];
            end
            n4_reg    <= n3_reg;
            clip4_reg <= clip3_reg;
        end
    end

    // stage 5: perp
    logic signed [127:0]  perp_next [3];
    logic                 clip5_next;
    logic signed [IW-1:0] perp5_reg [3];
    logic signed [W-1:0]  n5_reg [3];
    logic                 clip5_reg;

    always_comb
    begin
        clip5_next = clip4_reg;
        for (int i = 0; i < 3; i++)
        begin
            perp_next[i] = vr_pkg::rnd_shift(128'(et4_reg[i]), EF);
            clip5_next = clip5_next | vr_pkg::ovf32(perp_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                perp5_reg[i] <= vr_pkg::sat32(perp_next[i]);
            end
            n5_reg    <= n4_reg;
            clip5_reg <= clip5_next;
        end
    end

    // stage 6: perp squares
    logic signed [2*IW-1:0] pp6_reg [3];
    logic signed [IW-1:0]   perp6_reg [3];
    logic signed [W-1:0]    n6_reg [3];
    logic                   clip6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp6_reg[i] <= perp5_reg[i] * perp5_reg[i];
            end
            perp6_reg <= perp5_reg;
            n6_reg    <= n5_reg;
            clip6_reg <= clip5_reg;
        end
    end

    // stage 7: |1 - |perp|^2|
    logic signed [127:0] sq_next;
    logic signed [127:0] diff_next;
    logic [IW-1:0]        diff7_reg;
    logic signed [IW-1:0] perp7_reg [3];
    logic signed [W-1:0]  n7_reg [3];
    logic                 clip7_reg;

    always_comb
    begin
        sq_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            sq_next = sq_next + vr_pkg::rnd_shift(128'(pp6_reg[i]), F);
        end
        diff_next = ONE - 128'(vr_pkg::sat32(sq_next));
        if (diff_next < 0)
        begin
            diff_next = -diff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            diff7_reg <= diff_next[IW-1:0];
            perp7_reg <= perp6_reg;
            n7_reg    <= n6_reg;
            clip7_reg <= clip6_reg | vr_pkg::ovf32(sq_next);
        end
    end

    // square root: one result bit per stage, MSB first
    logic [SW-1:0]        sq_rem_reg  [RW];
    logic [RW-1:0]        sq_root_reg [RW];
    logic signed [IW-1:0] sq_perp_reg [RW][3];
    logic signed [W-1:0]  sq_n_reg    [RW][3];
    logic                 sq_clip_reg [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        localparam int K = RW - 1 - j;
        logic [SW-1:0]        rem_in;
        logic [RW-1:0]        root_in;
        logic signed [IW-1:0] perp_in [3];
        logic signed [W-1:0]  n_in_s [3];
        logic                 clip_in;
        logic [SW-1:0]        trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = SW'({diff7_reg, {F{1'b0}}});
            assign root_in = '0;
            assign perp_in = perp7_reg;
            assign n_in_s  = n7_reg;
            assign clip_in = clip7_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign perp_in = sq_perp_reg[j-1];
            assign n_in_s  = sq_n_reg[j-1];
            assign clip_in = sq_clip_reg[j-1];
        end

        assign trial = (SW'(root_in) << (K + 1)) + (SW'(1) << (2 * K));

        always_ff @(posedge clk)
        begin
            if (rdy[SQ0+j])
            begin
                if (rem_in >= trial)
                begin
                    sq_rem_reg[j]  <= rem_in - trial;
                    sq_root_reg[j] <= root_in | (RW'(1) << K);
                end
                else
                begin
                    sq_rem_reg[j]  <= rem_in;
                    sq_root_reg[j] <= root_in;
                end
                sq_perp_reg[j] <= perp_in;
                sq_n_reg[j]    <= n_in_s;
                sq_clip_reg[j] <= clip_in;
            end
        end
    end

    // root rounding
    logic [RW:0]          root_reg;
    logic signed [IW-1:0] perp_rt_reg [3];
    logic signed [W-1:0]  n_rt_reg [3];
    logic                 clip_rt_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[RTS])
        begin
            root_reg    <= {1'b0, sq_root_reg[RW-1]}
                           + (RW+1)'(sq_rem_reg[RW-1] > SW'(sq_root_reg[RW-1]));
            perp_rt_reg <= sq_perp_reg[RW-1];
            n_rt_reg    <= sq_n_reg[RW-1];
            clip_rt_reg <= sq_clip_reg[RW-1];
        end
    end

    // root * n
    logic signed [RW+W+1:0] par_reg [3];
    logic signed [IW-1:0]   perp_pr_reg [3];
    logic                   clip_pr_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[PRS])
        begin
            for (int i = 0; i < 3; i++)
            begin
                par_reg[i] <= $signed({1'b0, root_reg}) * n_rt_reg[i];
            end
            perp_pr_reg <= perp_rt_reg;
            clip_pr_reg <= clip_rt_reg;
        end
    end

    // output: perp - par, saturated to the component width
    logic signed [127:0] sum_next [3];
    logic signed [W-1:0] ref_next [3];
    logic                clip_out_next;
    logic signed [W-1:0] ref_reg [3];
    logic                clip_out_reg;

    always_comb
    begin
        clip_out_next = clip_pr_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = 128'(perp_pr_reg[i]) + vr_pkg::rnd_shift(-128'(par_reg[i]), F);
            if (sum_next[i] > OMAX)
            begin
                ref_next[i]   = OMAX[W-1:0];
                clip_out_next = 1'b1;
            end
            else if (sum_next[i] < OMIN)
            begin
                ref_next[i]   = OMIN[W-1:0];
                clip_out_next = 1'b1;
            end
            else
            begin
                ref_next[i] = sum_next[i][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            ref_reg      <= ref_next;
            clip_out_reg <= clip_out_next;
        end
    end

    assign res.valid   = valid_reg[NS-1];
    assign res.ref_x   = ref_reg[0];
    assign res.ref_y   = ref_reg[1];
    assign res.ref_z   = ref_reg[2];
    assign res.clipped = clip_out_reg;

endmodule

[rtl/vr_checker.sv]
// Port-level checks for the refraction unit, bound to the top level.
`include "assert_macros.svh"

module vr_checker #(
    parameter int COMP_WIDTH = vr_pkg::COMP_WIDTH
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         hit_valid,
    input logic                         hit_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [COMP_WIDTH-1:0] ref_x,
    input logic signed [COMP_WIDTH-1:0] ref_y,
    input logic signed [COMP_WIDTH-1:0] ref_z,
    input logic                         clipped
);
    // an empty or draining output stage lets every stage move
    `VR_ASSERT_NOW(a_ready_when_empty, !res_valid, hit_ready, "hit blocked with empty output")
    `VR_ASSERT_NOW(a_ready_when_drain, res_ready, hit_ready, "hit blocked while output drains")
    `VR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped")
    `VR_ASSERT_NEXT(a_res_stable, res_valid && !res_ready,
        $stable(ref_x) && $stable(ref_y) && $stable(ref_z) && $stable(clipped),
        "stalled result word changed")

endmodule

bind vector_refract_unit vr_checker #(.COMP_WIDTH(COMP_WIDTH)) u_vr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_valid (hit.valid),
    .hit_ready (hit.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .ref_x     (res.ref_x),
    .ref_y     (res.ref_y),
    .ref_z     (res.ref_z),
    .clipped   (res.clipped)
);
